### rtl/pts_pkg.sv
// Shared types, constants, microcode ROM and helper functions of the task scheduler.
package pts_pkg;

    localparam int TASK_SLOTS = 32;
    localparam int MAP_W      = TASK_SLOTS - 1;
    localparam int PRIO_W     = 5;
    localparam int TYPE_W     = 3;
    localparam int ID_W       = 5;
    localparam int TICK_W     = 32;
    localparam int IDX_W      = $clog2(TASK_SLOTS);
    localparam int CNT_AW     = (MAP_W > 1) ? $clog2(MAP_W) : 1;
    localparam int UPC_W      = 5;

    localparam logic [TYPE_W-1:0] REQ_START    = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_STOP     = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_RELEASE  = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_DELETE   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_DELAY    = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_TICK     = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_SCHEDULE = 3'd6;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [ID_W-1:0]   task_id;
        logic [TICK_W-1:0] delay_ticks;
    } sched_req_t;

    typedef struct packed {
        logic [PRIO_W-1:0] next_priority;
        logic              switch_needed;
        logic              bad_request;
        logic [MAP_W-1:0]  ready_bits;
    } sched_rsp_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_MARK_ID_ON,
        UOP_MARK_ID_OFF,
        UOP_MARK_CUR_OFF,
        UOP_LOAD_DELAY,
        UOP_SCHEDULE,
        UOP_SCAN_INIT,
        UOP_SCAN_STEP,
        UOP_SET_BAD
    } uop_e;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_BAD_ID,
        COND_NO_CUR,
        COND_SCAN_MORE
    } cond_e;

    typedef struct packed {
        uop_e             uop;
        cond_e            cond;
        logic [UPC_W-1:0] target;
        logic             last;
    } uword_t;

    typedef struct packed {
        logic load;
        logic emit;
        uop_e uop;
    } dp_ctrl_t;

    typedef struct packed {
        logic bad_id;
        logic no_cur;
        logic scan_more;
    } dp_status_t;

    // microcode addresses
    localparam logic [UPC_W-1:0] UA_START         = 5'd0;
    localparam logic [UPC_W-1:0] UA_START_MARK    = 5'd1;
    localparam logic [UPC_W-1:0] UA_STOP          = 5'd2;
    localparam logic [UPC_W-1:0] UA_STOP_MARK     = 5'd3;
    localparam logic [UPC_W-1:0] UA_RELEASE       = 5'd4;
    localparam logic [UPC_W-1:0] UA_RELEASE_MARK  = 5'd5;
    localparam logic [UPC_W-1:0] UA_RELEASE_SCHED = 5'd6;
    localparam logic [UPC_W-1:0] UA_DELETE        = 5'd7;
    localparam logic [UPC_W-1:0] UA_DELETE_MARK   = 5'd8;
    localparam logic [UPC_W-1:0] UA_DELETE_SCHED  = 5'd9;
    localparam logic [UPC_W-1:0] UA_DELAY         = 5'd10;
    localparam logic [UPC_W-1:0] UA_DELAY_LOAD    = 5'd11;
    localparam logic [UPC_W-1:0] UA_DELAY_SCHED   = 5'd12;
    localparam logic [UPC_W-1:0] UA_TICK          = 5'd13;
    localparam logic [UPC_W-1:0] UA_TICK_SCAN     = 5'd14;
    localparam logic [UPC_W-1:0] UA_TICK_DRAIN    = 5'd15;
    localparam logic [UPC_W-1:0] UA_SCHED         = 5'd16;
    localparam logic [UPC_W-1:0] UA_NONE          = 5'd17;
    localparam logic [UPC_W-1:0] UA_BAD           = 5'd18;

    function automatic uword_t uw(input uop_e op, input cond_e cond,
                                  input logic [UPC_W-1:0] target, input logic last);
        uword_t w;
        w.uop    = op;
        w.cond   = cond;
        w.target = target;
        w.last   = last;
        return w;
    endfunction

    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        uword_t w;
        unique case (addr)
            UA_START:         w = uw(UOP_NOP,          COND_BAD_ID,    UA_BAD,       1'b0);
            UA_START_MARK:    w = uw(UOP_MARK_ID_ON,   COND_NONE,      UA_NONE,      1'b1);
            UA_STOP:          w = uw(UOP_NOP,          COND_BAD_ID,    UA_BAD,       1'b0);
            UA_STOP_MARK:     w = uw(UOP_MARK_ID_OFF,  COND_NONE,      UA_NONE,      1'b1);
            UA_RELEASE:       w = uw(UOP_NOP,          COND_BAD_ID,    UA_BAD,       1'b0);
            UA_RELEASE_MARK:  w = uw(UOP_MARK_ID_ON,   COND_NONE,      UA_NONE,      1'b0);
            UA_RELEASE_SCHED: w = uw(UOP_SCHEDULE,     COND_NONE,      UA_NONE,      1'b1);
            UA_DELETE:        w = uw(UOP_NOP,          COND_NO_CUR,    UA_BAD,       1'b0);
            UA_DELETE_MARK:   w = uw(UOP_MARK_CUR_OFF, COND_NONE,      UA_NONE,      1'b0);
            UA_DELETE_SCHED:  w = uw(UOP_SCHEDULE,     COND_NONE,      UA_NONE,      1'b1);
            UA_DELAY:         w = uw(UOP_NOP,          COND_NO_CUR,    UA_BAD,       1'b0);
            UA_DELAY_LOAD:    w = uw(UOP_LOAD_DELAY,   COND_NONE,      UA_NONE,      1'b0);
            UA_DELAY_SCHED:   w = uw(UOP_SCHEDULE,     COND_NONE,      UA_NONE,      1'b1);
            UA_TICK:          w = uw(UOP_SCAN_INIT,    COND_NONE,      UA_NONE,      1'b0);
            UA_TICK_SCAN:     w = uw(UOP_SCAN_STEP,    COND_SCAN_MORE, UA_TICK_SCAN, 1'b0);
            UA_TICK_DRAIN:    w = uw(UOP_SCAN_STEP,    COND_NONE,      UA_NONE,      1'b1);
            UA_SCHED:         w = uw(UOP_SCHEDULE,     COND_NONE,      UA_NONE,      1'b1);
            UA_NONE:          w = uw(UOP_NOP,          COND_NONE,      UA_NONE,      1'b1);
            UA_BAD:           w = uw(UOP_SET_BAD,      COND_NONE,      UA_NONE,      1'b1);
            default:          w = uw(UOP_NOP,          COND_NONE,      UA_NONE,      1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] dispatch(input logic [TYPE_W-1:0] req_type);
        logic [UPC_W-1:0] a;
        unique case (req_type)
            REQ_START:    a = UA_START;
            REQ_STOP:     a = UA_STOP;
            REQ_RELEASE:  a = UA_RELEASE;
            REQ_DELETE:   a = UA_DELETE;
            REQ_DELAY:    a = UA_DELAY;
            REQ_TICK:     a = UA_TICK;
            REQ_SCHEDULE: a = UA_SCHED;
            default:      a = UA_NONE;
        endcase
        return a;
    endfunction

    function automatic logic [PRIO_W-1:0] highest_ready(input logic [MAP_W-1:0] map);
        logic [PRIO_W-1:0] res;
        res = '0;
        for (int p = 0; p < MAP_W; p++)
        begin
            if (map[p])
                res = PRIO_W'(p + 1);
        end
        return res;
    endfunction

endpackage

### rtl/pts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 31
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### rtl/pts_useq.sv
// Microcode sequencer: step counter, control ROM, conditional jumps and result strobe.
module pts_useq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pts_pkg::TYPE_W-1:0]  req_type,
    input  pts_pkg::dp_status_t         status,
    output logic                        busy,
    output logic                        done,
    output pts_pkg::dp_ctrl_t           ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [pts_pkg::UPC_W-1:0]   pc_reg, pc_next;
    logic                        done_reg, done_next;
    pts_pkg::uword_t             word;
    logic                        taken;

    assign word = pts_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        unique case (word.cond)
            pts_pkg::COND_NONE:      taken = 1'b0;
            pts_pkg::COND_BAD_ID:    taken = status.bad_id;
            pts_pkg::COND_NO_CUR:    taken = status.no_cur;
            pts_pkg::COND_SCAN_MORE: taken = status.scan_more;
            default:                 taken = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    pc_next    = pts_pkg::dispatch(req_type);
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (taken)
                    pc_next = word.target;
                else if (word.last)
                    state_next = S_EMIT;
                else
                    pc_next = pc_reg + pts_pkg::UPC_W'(1);
            end
            S_EMIT:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= pts_pkg::UA_NONE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            done_reg  <= done_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign ctrl.load = start && (state_reg == S_IDLE);
    assign ctrl.emit = (state_reg == S_EMIT);
    assign ctrl.uop  = (state_reg == S_RUN) ? word.uop : pts_pkg::UOP_NOP;

endmodule

### rtl/pts_datapath.sv
// Scheduler datapath: ready/delay maps, current task, tick counter RAM and result register.
module pts_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pts_pkg::sched_req_t  request,
    input  pts_pkg::dp_ctrl_t    ctrl,
    output pts_pkg::dp_status_t  status,
    output pts_pkg::sched_rsp_t  result
);

    pts_pkg::sched_req_t             item_reg, item_next;
    pts_pkg::sched_rsp_t             result_reg, result_next;
    logic [pts_pkg::MAP_W-1:0]       ready_reg, ready_next;
    logic [pts_pkg::MAP_W-1:0]       delay_reg, delay_next;
    logic [pts_pkg::PRIO_W-1:0]      cur_reg, cur_next;
    logic                            cur_valid_reg, cur_valid_next;
    logic                            sw_reg, sw_next;
    logic                            bad_reg, bad_next;
    logic [pts_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic                            pend_reg, pend_next;
    logic [pts_pkg::CNT_AW-1:0]      pend_idx_reg, pend_idx_next;

    logic                            ram_we;
    logic [pts_pkg::CNT_AW-1:0]      ram_waddr;
    logic [pts_pkg::TICK_W-1:0]      ram_wdata;
    logic [pts_pkg::CNT_AW-1:0]      ram_raddr;
    logic [pts_pkg::TICK_W-1:0]      ram_rdata;

    logic [pts_pkg::PRIO_W-1:0]      prio_id;
    logic [pts_pkg::PRIO_W-1:0]      sched_prio;
    logic [pts_pkg::MAP_W-1:0]       id_mask;
    logic [pts_pkg::MAP_W-1:0]       cur_mask;
    logic [pts_pkg::MAP_W-1:0]       pend_mask;
    logic [pts_pkg::TICK_W-1:0]      rd_dec;

    pts_ram #(
        .WIDTH (pts_pkg::TICK_W),
        .DEPTH (pts_pkg::MAP_W)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign prio_id    = pts_pkg::PRIO_W'(pts_pkg::TASK_SLOTS - int'(item_reg.task_id));
    assign id_mask    = pts_pkg::MAP_W'(1) << (prio_id - pts_pkg::PRIO_W'(1));
    assign cur_mask   = pts_pkg::MAP_W'(1) << (cur_reg - pts_pkg::PRIO_W'(1));
    assign pend_mask  = pts_pkg::MAP_W'(1) << pend_idx_reg;
    assign rd_dec     = ram_rdata - pts_pkg::TICK_W'(1);
    assign sched_prio = pts_pkg::highest_ready(ready_reg);

    assign status.bad_id    = (item_reg.task_id == '0)
                           || (int'(item_reg.task_id) >= pts_pkg::TASK_SLOTS);
    assign status.no_cur    = !cur_valid_reg || (cur_reg == '0);
    assign status.scan_more = (idx_reg != pts_pkg::IDX_W'(pts_pkg::MAP_W - 1));

    always_comb
    begin
        item_next      = item_reg;
        result_next    = result_reg;
        ready_next     = ready_reg;
        delay_next     = delay_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        sw_next        = sw_reg;
        bad_next       = bad_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_idx_reg;
        ram_wdata      = rd_dec;
        ram_raddr      = idx_reg[pts_pkg::CNT_AW-1:0];

        unique case (ctrl.uop)
            pts_pkg::UOP_NOP:
            begin
            end
            pts_pkg::UOP_MARK_ID_ON:
            begin
                ready_next = ready_reg | id_mask;
                delay_next = delay_reg & ~id_mask;
            end
            pts_pkg::UOP_MARK_ID_OFF:
            begin
                ready_next = ready_reg & ~id_mask;
                delay_next = delay_reg & ~id_mask;
            end
            pts_pkg::UOP_MARK_CUR_OFF:
            begin
                ready_next = ready_reg & ~cur_mask;
                delay_next = delay_reg & ~cur_mask;
            end
            pts_pkg::UOP_LOAD_DELAY:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pts_pkg::CNT_AW'(cur_reg - pts_pkg::PRIO_W'(1));
                ram_wdata  = item_reg.delay_ticks;
                delay_next = delay_reg | cur_mask;
                ready_next = ready_reg & ~cur_mask;
            end
            pts_pkg::UOP_SCHEDULE:
            begin
                sw_next        = !cur_valid_reg || (sched_prio != cur_reg);
                cur_next       = sched_prio;
                cur_valid_next = 1'b1;
            end
            pts_pkg::UOP_SCAN_INIT:
            begin
                idx_next  = '0;
                pend_next = 1'b0;
            end
            pts_pkg::UOP_SCAN_STEP:
            begin
                // retire the counter read last cycle, issue the next read
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                    if (rd_dec == '0)
                    begin
                        ready_next = ready_reg | pend_mask;
                        delay_next = delay_reg & ~pend_mask;
                    end
                end
                pend_next = 1'b0;
                if (idx_reg < pts_pkg::IDX_W'(pts_pkg::MAP_W))
                begin
                    pend_next     = delay_reg[idx_reg[pts_pkg::CNT_AW-1:0]];
                    pend_idx_next = idx_reg[pts_pkg::CNT_AW-1:0];
                    idx_next      = idx_reg + pts_pkg::IDX_W'(1);
                end
            end
            pts_pkg::UOP_SET_BAD:
                bad_next = 1'b1;
            default:
            begin
            end
        endcase

        if (ctrl.load)
        begin
            item_next = request;
            sw_next   = 1'b0;
            bad_next  = 1'b0;
        end

        if (ctrl.emit)
        begin
            result_next.next_priority = sched_prio;
            result_next.switch_needed = sw_reg;
            result_next.bad_request   = bad_reg;
            result_next.ready_bits    = ready_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg     <= '0;
            delay_reg     <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            ready_reg     <= ready_next;
            delay_reg     <= delay_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        result_reg   <= result_next;
        sw_reg       <= sw_next;
        bad_reg      <= bad_next;
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
    end

    assign result = result_reg;

endmodule

### rtl/priority_task_scheduler.sv
// Top level of the bitmap priority task scheduler.
//
// Request channel: a transfer happens on a rising edge with start high and busy low;
// request carries req_type, task_id and delay_ticks. busy stays high until the
// request has been run by the microcode sequencer.
// Result channel: done is high for exactly one cycle with result valid (next_priority,
// switch_needed, bad_request, ready_bits). The receiver cannot stall; it must take the
// transfer in that cycle. A new request may be started in the same cycle as done.
// From request transfer to done the sequencer runs the microcode steps, then its emit
// state. Start, stop and error paths run 2 steps, release/delete/delay 3 steps and
// schedule 1 step. A tick walks the tick counter RAM one entry per cycle, 33 steps in
// all, set by the single read and write port of that RAM.
// Only one request is in flight: no new request is taken while busy is high.
// Reset (rst_n low, asynchronous) empties ready and delay maps and clears the current
// task; tick counters are not cleared and only count once a delay request loads them.
module priority_task_scheduler (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  pts_pkg::sched_req_t request,
    output logic                busy,
    output logic                done,
    output pts_pkg::sched_rsp_t result
);

    pts_pkg::dp_ctrl_t   ctrl;
    pts_pkg::dp_status_t status;

    pts_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .status   (status),
        .busy     (busy),
        .done     (done),
        .ctrl     (ctrl)
    );

    pts_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctrl    (ctrl),
        .status  (status),
        .result  (result)
    );

endmodule

### rtl/pts_checker.sv
// Port-level checker for the task scheduler, bound to the top level.
module pts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input pts_pkg::sched_req_t request,
    input logic                busy,
    input logic                done,
    input pts_pkg::sched_rsp_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_prio_map: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.next_priority == '0) == (result.ready_bits == '0)))
        else $error("next_priority disagrees with ready_bits");

    a_bad_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.bad_request) |-> !result.switch_needed)
        else $error("refused request flagged a switch");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (.*);

### tb/tb.sv
// Self-checking testbench for the priority task scheduler: directed and random requests.
`timescale 1ns / 1ps

module tb;

    localparam logic [pts_pkg::TYPE_W-1:0] REQ_RESERVED = 3'd7;
    localparam int                         ERR_SHOWN    = 10;
    localparam int                         DRAIN_CYCLES = 40;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    pts_pkg::sched_req_t request;
    logic                busy;
    logic                done;
    pts_pkg::sched_rsp_t result;

    // scheduler shadow state
    logic [pts_pkg::MAP_W-1:0]  ready_map;
    logic [pts_pkg::MAP_W-1:0]  delay_map;
    logic [pts_pkg::TICK_W-1:0] tick_count [pts_pkg::MAP_W];
    logic [pts_pkg::PRIO_W-1:0] running_prio;
    logic                       running_valid;

    pts_pkg::sched_rsp_t expected_results [$];
    pts_pkg::sched_rsp_t want;
    int                  err_count;
    int                  burst_left;

    priority_task_scheduler u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [pts_pkg::PRIO_W-1:0] top_ready(
        input logic [pts_pkg::MAP_W-1:0] map);
        for (int p = pts_pkg::MAP_W; p >= 1; p--)
        begin
            if (map[p-1])
                return pts_pkg::PRIO_W'(p);
        end
        return '0;
    endfunction

    function automatic logic pick_next();
        logic [pts_pkg::PRIO_W-1:0] nxt;
        logic                       sw;
        nxt           = top_ready(ready_map);
        sw            = !running_valid || (nxt != running_prio);
        running_prio  = nxt;
        running_valid = 1'b1;
        return sw;
    endfunction

    function automatic pts_pkg::sched_rsp_t predict_step(input pts_pkg::sched_req_t rq);
        pts_pkg::sched_rsp_t rsp;
        logic                sw;
        logic                bad;
        logic                has_task;
        int                  bit_idx;
        sw       = 1'b0;
        bad      = 1'b0;
        has_task = running_valid && (running_prio != 0);
        case (rq.req_type)
            pts_pkg::REQ_START, pts_pkg::REQ_STOP, pts_pkg::REQ_RELEASE:
            begin
                if (rq.task_id == 0 || rq.task_id >= pts_pkg::TASK_SLOTS)
                    bad = 1'b1;
                else
                begin
                    bit_idx = pts_pkg::TASK_SLOTS - 1 - int'(rq.task_id);
                    ready_map[bit_idx] = (rq.req_type != pts_pkg::REQ_STOP);
                    delay_map[bit_idx] = 1'b0;
                    if (rq.req_type == pts_pkg::REQ_RELEASE)
                        sw = pick_next();
                end
            end
            pts_pkg::REQ_DELETE:
            begin
                if (!has_task)
                    bad = 1'b1;
                else
                begin
                    ready_map[running_prio-1] = 1'b0;
                    delay_map[running_prio-1] = 1'b0;
                    sw = pick_next();
                end
            end
            pts_pkg::REQ_DELAY:
            begin
                if (!has_task)
                    bad = 1'b1;
                else
                begin
                    tick_count[running_prio-1] = rq.delay_ticks;
                    delay_map[running_prio-1]  = 1'b1;
                    ready_map[running_prio-1]  = 1'b0;
                    sw = pick_next();
                end
            end
            pts_pkg::REQ_TICK:
            begin
                for (int i = 0; i < pts_pkg::MAP_W; i++)
                begin
                    if (delay_map[i])
                    begin
                        tick_count[i] = tick_count[i] - 1;
                        if (tick_count[i] == 0)
                        begin
                            ready_map[i] = 1'b1;
                            delay_map[i] = 1'b0;
                        end
                    end
                end
            end
            pts_pkg::REQ_SCHEDULE:
                sw = pick_next();
            default:
                ;
        endcase
        rsp.next_priority = top_ready(ready_map);
        rsp.switch_needed = sw;
        rsp.bad_request   = bad;
        rsp.ready_bits    = ready_map;
        return rsp;
    endfunction

    function automatic pts_pkg::sched_req_t mk_req(
        input logic [pts_pkg::TYPE_W-1:0] kind,
        input logic [pts_pkg::ID_W-1:0]   id,
        input logic [pts_pkg::TICK_W-1:0] ticks);
        pts_pkg::sched_req_t rq;
        rq.req_type    = kind;
        rq.task_id     = id;
        rq.delay_ticks = ticks;
        return rq;
    endfunction

    // one request transfer, preceded by a random, possibly empty idle gap
    task automatic issue_request(input pts_pkg::sched_req_t rq);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(5, 20);
            gap = $urandom_range(0, 16);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   = 1'b1;
        request = rq;
        do
            @(posedge clk);
        while (busy);
        expected_results.push_back(predict_step(rq));
    endtask

    function automatic logic [pts_pkg::TICK_W-1:0] short_delay();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    function automatic logic [pts_pkg::ID_W-1:0] any_id();
        if ($urandom_range(0, 24) == 0)
            return '0;
        return pts_pkg::ID_W'($urandom_range(1, pts_pkg::TASK_SLOTS - 1));
    endfunction

    task automatic test_directed();
        issue_request(mk_req(pts_pkg::REQ_DELETE, 5'd0, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_DELAY, 5'd5, 32'd3));
        issue_request(mk_req(pts_pkg::REQ_SCHEDULE, 5'd0, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_DELETE, 5'd0, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_DELAY, 5'd0, 32'd7));
        issue_request(mk_req(pts_pkg::REQ_START, 5'd0, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_STOP, 5'd0, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_RELEASE, 5'd0, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_START, 5'd31, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_START, 5'd1, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_STOP, 5'd1, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_RELEASE, 5'd16, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_DELAY, 5'd0, 32'd2));
        issue_request(mk_req(pts_pkg::REQ_TICK, 5'd0, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_TICK, 5'd0, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_SCHEDULE, 5'd0, 32'd0));
        // zero delay wraps on the next tick
        issue_request(mk_req(pts_pkg::REQ_DELAY, 5'd0, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_TICK, 5'd0, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_START, 5'd16, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_RELEASE, 5'd31, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_DELAY, 5'd0, 32'hFFFF_FFFF));
        issue_request(mk_req(pts_pkg::REQ_STOP, 5'd16, 32'd0));
        issue_request(mk_req(REQ_RESERVED, 5'd31, 32'hFFFF_FFFF));
        issue_request(mk_req(pts_pkg::REQ_DELETE, 5'd0, 32'd0));
        issue_request(mk_req(pts_pkg::REQ_SCHEDULE, 5'd0, 32'd0));
    endtask

    // tasks repeatedly released, delayed for a few ticks and woken up
    task automatic test_delay_wakeup(input int n);
        int roll;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                issue_request(mk_req(pts_pkg::REQ_RELEASE, any_id(), $urandom));
            else if (roll < 50)
                issue_request(mk_req(pts_pkg::REQ_DELAY, pts_pkg::ID_W'($urandom),
                                     short_delay()));
            else if (roll < 85)
                issue_request(mk_req(pts_pkg::REQ_TICK, pts_pkg::ID_W'($urandom), $urandom));
            else
                issue_request(mk_req(pts_pkg::REQ_SCHEDULE, pts_pkg::ID_W'($urandom),
                                     $urandom));
        end
    endtask

    task automatic test_random_mix(input int n);
        int roll;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 18)
                issue_request(mk_req(pts_pkg::REQ_RELEASE, any_id(), $urandom));
            else if (roll < 28)
                issue_request(mk_req(pts_pkg::REQ_START, any_id(), $urandom));
            else if (roll < 36)
                issue_request(mk_req(pts_pkg::REQ_STOP, any_id(), $urandom));
            else if (roll < 44)
                issue_request(mk_req(pts_pkg::REQ_DELETE, pts_pkg::ID_W'($urandom),
                                     $urandom));
            else if (roll < 62)
                issue_request(mk_req(pts_pkg::REQ_DELAY, pts_pkg::ID_W'($urandom),
                                     short_delay()));
            else if (roll < 84)
                issue_request(mk_req(pts_pkg::REQ_TICK, pts_pkg::ID_W'($urandom), $urandom));
            else if (roll < 95)
                issue_request(mk_req(pts_pkg::REQ_SCHEDULE, pts_pkg::ID_W'($urandom),
                                     $urandom));
            else
                issue_request(mk_req(REQ_RESERVED, pts_pkg::ID_W'($urandom), $urandom));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                err_count++;
                if (err_count <= ERR_SHOWN)
                    $display("ERROR: unexpected result transfer %h", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.next_priority !== want.next_priority ||
                    result.switch_needed !== want.switch_needed ||
                    result.bad_request   !== want.bad_request   ||
                    result.ready_bits    !== want.ready_bits)
                begin
                    err_count++;
                    if (err_count <= ERR_SHOWN)
                    begin
                        $display("ERROR: exp prio %0d sw %b bad %b ready %h",
                                 want.next_priority, want.switch_needed,
                                 want.bad_request, want.ready_bits);
                        $display("       got prio %0d sw %b bad %b ready %h",
                                 result.next_priority, result.switch_needed,
                                 result.bad_request, result.ready_bits);
                    end
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("priority_task_scheduler verification failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        request       = '0;
        ready_map     = '0;
        delay_map     = '0;
        running_prio  = '0;
        running_valid = 1'b0;
        err_count     = 0;
        burst_left    = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_delay_wakeup(150);
        test_random_mix(300);

        @(negedge clk);
        start = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("priority_task_scheduler verification clean");
        else
            $display("priority_task_scheduler verification failed");
        $finish;
    end

endmodule
